FILE: rtl/mu8_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the modified utf-8 decoder
// no dependencies

package mu8_pkg;

	localparam int BYTE_W  = 8;
	localparam int UNIT_W  = 16;
	localparam int SLOTS   = 3;
	localparam int SLOT_W  = 2;
	localparam int DEPTH   = 2;
	localparam int PTR_W   = 1;
	localparam int FILL_W  = 2;

	// byte classes
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
	localparam logic [3:0]        BAD_NIB    = 4'hF;

	// pending byte count
	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_LEAD = 2'd1;
	localparam logic [1:0] HELD_MID  = 2'd2;

	// all results caused by one input byte
	typedef struct packed {
		logic [SLOTS-1:0][UNIT_W-1:0] units;
		logic [SLOTS-1:0]             bad;
		logic [SLOT_W-1:0]            cnt;
		logic                         eos;
	} bundle_t;

	function automatic logic is_cont(input logic [BYTE_W-1:0] b);
		return (b & CONT_MASK) == CONT_TAG;
	endfunction

	function automatic logic [UNIT_W-1:0] raw_unit(input logic [BYTE_W-1:0] b);
		return {{(UNIT_W-BYTE_W){1'b0}}, b};
	endfunction

endpackage

FILE: rtl/mu8_byte_if.sv
`timescale 1ns / 1ps
// byte channel: valid, ready and one string byte
// depends on mu8_pkg

interface mu8_byte_if import mu8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_string;

	modport source (output valid, data_byte, end_of_string, input ready);
	modport sink (input valid, data_byte, end_of_string, output ready);
endinterface

FILE: rtl/mu8_unit_if.sv
`timescale 1ns / 1ps
// code unit channel: valid, ready and one decoded result
// depends on mu8_pkg

interface mu8_unit_if import mu8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	logic              malformed;
	logic              last_of_run;
	logic              string_done;

	modport source (output valid, code_unit, malformed, last_of_run, string_done,
		input ready);
	modport sink (input valid, code_unit, malformed, last_of_run, string_done,
		output ready);
endinterface

FILE: rtl/mu8_front.sv
`timescale 1ns / 1ps
// front part: accepts bytes, tracks pending sequence, builds result bundles
// depends on mu8_pkg, mu8_byte_if

module mu8_front import mu8_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mu8_byte_if.sink  bytes,
	input  logic      q_full,
	output logic      push,
	output bundle_t   push_data
);

	logic [BYTE_W-1:0] lead_q, mid_q;
	logic [1:0]        count_q;

	logic [BYTE_W-1:0] b, nl, nm;
	logic [1:0]        nc;
	logic [SLOT_W-1:0] n;
	logic              cont, ascii, fresh_emit, do_fresh;
	logic              e_dec, e_lead, e_mid;
	logic [UNIT_W-1:0] dec_unit;
	bundle_t           bnd;
	logic              xfer;

	assign bytes.ready = !q_full;
	assign xfer        = bytes.valid && !q_full;
	assign push        = xfer && (bnd.cnt != '0);
	assign push_data   = bnd;

	always_comb begin
		b          = bytes.data_byte;
		cont       = is_cont(b);
		ascii      = !b[BYTE_W-1];
		fresh_emit = ascii || cont || (b[BYTE_W-1:BYTE_W-4] == BAD_NIB);
		nl         = lead_q;
		nm         = mid_q;
		nc         = count_q;
		do_fresh   = 1'b0;
		e_dec      = 1'b0;
		e_lead     = 1'b0;
		e_mid      = 1'b0;
		dec_unit   = '0;
		case (count_q)
			HELD_NONE: do_fresh = 1'b1;
			HELD_LEAD: begin
				if (!cont) begin
					e_lead   = 1'b1;
					do_fresh = 1'b1;
				end else if ((lead_q & LEAD2_MASK) == LEAD2_TAG) begin
					e_dec    = 1'b1;
					dec_unit = {5'b0, lead_q[4:0], b[5:0]};
					nc       = HELD_NONE;
				end else begin
					nm = b;
					nc = HELD_MID;
				end
			end
			default: begin
				// two pending, an impossible count of three behaves the same
				if (cont) begin
					e_dec    = 1'b1;
					dec_unit = {lead_q[3:0], mid_q[5:0], b[5:0]};
					nc       = HELD_NONE;
				end else begin
					e_lead   = 1'b1;
					e_mid    = 1'b1;
					do_fresh = 1'b1;
				end
			end
		endcase
		if (do_fresh) begin
			if (fresh_emit) begin
				nc = HELD_NONE;
			end else begin
				nl = b;
				nc = HELD_LEAD;
			end
		end

		bnd     = '0;
		bnd.eos = bytes.end_of_string;
		n       = '0;
		if (e_dec) begin
			bnd.units[n] = dec_unit;
			bnd.bad[n]   = 1'b0;
			n            = n + 1'b1;
		end
		if (e_lead) begin
			bnd.units[n] = raw_unit(lead_q);
			bnd.bad[n]   = 1'b1;
			n            = n + 1'b1;
		end
		if (e_mid) begin
			bnd.units[n] = raw_unit(mid_q);
			bnd.bad[n]   = 1'b1;
			n            = n + 1'b1;
		end
		if (do_fresh && fresh_emit) begin
			bnd.units[n] = raw_unit(b);
			bnd.bad[n]   = !ascii;
			n            = n + 1'b1;
		end
		// end of string flushes what is still pending
		if (bytes.end_of_string) begin
			if (nc != HELD_NONE) begin
				bnd.units[n] = raw_unit(nl);
				bnd.bad[n]   = 1'b1;
				n            = n + 1'b1;
			end
			if (nc == HELD_MID) begin
				bnd.units[n] = raw_unit(nm);
				bnd.bad[n]   = 1'b1;
				n            = n + 1'b1;
			end
			nc = HELD_NONE;
		end
		bnd.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= HELD_NONE;
			lead_q  <= '0;
			mid_q   <= '0;
		end else if (xfer) begin
			count_q <= nc;
			lead_q  <= nl;
			mid_q   <= nm;
		end
	end

endmodule

FILE: rtl/mu8_fifo.sv
`timescale 1ns / 1ps
// two-entry bundle queue between front and back parts
// depends on mu8_pkg

module mu8_fifo import mu8_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output bundle_t head
);

	bundle_t           mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [FILL_W-1:0] fill_q;

	assign full  = (fill_q == FILL_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			fill_q <= fill_q + FILL_W'(push) - FILL_W'(pop);
		end
	end

endmodule

FILE: rtl/mu8_back.sv
`timescale 1ns / 1ps
// back part: walks the head bundle one code unit per transfer into the output register
// depends on mu8_pkg, mu8_unit_if

module mu8_back import mu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  bundle_t    q_head,
	output logic       q_pop,
	mu8_unit_if.source units
);

	logic [SLOT_W-1:0] idx_q;
	logic              valid_q;
	logic [UNIT_W-1:0] unit_q;
	logic              bad_q, last_q, done_q;

	logic              load, take, last;
	logic [UNIT_W-1:0] sel_unit;
	logic              sel_bad;

	assign load  = !valid_q || units.ready;
	assign take  = load && !q_empty;
	assign last  = (idx_q == q_head.cnt - 1'b1);
	assign q_pop = take && last;

	always_comb begin
		case (idx_q)
			2'd0:    begin sel_unit = q_head.units[0]; sel_bad = q_head.bad[0]; end
			2'd1:    begin sel_unit = q_head.units[1]; sel_bad = q_head.bad[1]; end
			default: begin sel_unit = q_head.units[2]; sel_bad = q_head.bad[2]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (take) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			unit_q <= sel_unit;
			bad_q  <= sel_bad;
			last_q <= last;
			done_q <= last && q_head.eos;
		end
	end

	assign units.valid       = valid_q;
	assign units.code_unit   = unit_q;
	assign units.malformed   = bad_q;
	assign units.last_of_run = last_q;
	assign units.string_done = done_q;

endmodule

FILE: rtl/modified_utf8_to_utf16_decoder.sv
`timescale 1ns / 1ps
// top level of the modified utf-8 to utf-16 decoder
// depends on mu8_pkg, mu8_byte_if, mu8_unit_if, mu8_front, mu8_fifo, mu8_back
//
// usage:
//   bytes: one string byte per transfer, end_of_string set on the final byte
//   units: one utf-16 code unit per transfer, with malformed, last_of_run and
//          string_done flags; a byte causes zero to three code units
// the first code unit of a byte is written into the queue on its byte's
//   transfer and then loaded into the output register before it shows on units
// throughput: one byte per cycle while each byte gives at most one code unit and
//   the receiver does not stall; a byte that gives several units holds the output
//   until each has gone through the single output register, one unit per transfer
// a two-entry queue separates the byte side from the unit side, so bytes
//   keep flowing while a finished unit waits to be taken
// when the receiver stalls the queue fills and bytes.ready drops after two
//   bundles are waiting; nothing is lost or repeated
// reset clears the pending sequence, the queue and the output valid flag

module modified_utf8_to_utf16_decoder import mu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mu8_byte_if.sink   bytes,
	mu8_unit_if.source units
);

	// front to queue
	logic    push, q_full;
	bundle_t push_data;

	// queue to back
	logic    q_pop, q_empty;
	bundle_t q_head;

	// classifies bytes and assembles sequences, one byte per cycle while the queue has room
	mu8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// holds bundles of results until the back part has sent them
	mu8_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// serializes each bundle into code unit transfers
	mu8_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.units   (units)
	);

endmodule

FILE: tb/modified_utf8_to_utf16_decoder_test.sv
`timescale 1ns / 1ps
// self-checking bench for the modified utf-8 to utf-16 decoder: directed and random strings
// with random sender gaps and receiver stalls, every code unit checked against a local decoder
// depends on mu8_pkg, mu8_byte_if, mu8_unit_if and modified_utf8_to_utf16_decoder

module modified_utf8_to_utf16_decoder_test;
	import mu8_pkg::*;

	localparam int CLK_HALF    = 4;
	localparam int RESET_LEN   = 11;
	localparam int MAX_GAP     = 13;
	localparam int RANDOM_LEN  = 400;
	localparam int IDLE_LIMIT  = 1000;
	localparam int DRAIN_WAIT  = 16;

	// one byte waiting to be sent, with the idle cycles that come before it
	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              eos;
		int unsigned       gap;
	} byte_req_t;

	// one code unit that the decoder must produce
	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		logic              malformed;
		logic              last_of_run;
		logic              string_done;
	} unit_rec_t;

	// directed opening: extremes, every sequence length, each malformed case,
	// and end of string with one or two bytes still held
	localparam logic [8:0] OPENING [27] = '{
		9'h000, 9'h07F,                 // ascii extremes
		9'h080, 9'h0FF,                 // stray continuation, 1111 lead
		9'h0C0, 9'h080,                 // overlong zero
		9'h0DF, 9'h0BF,                 // largest two-byte unit
		9'h0E0, 9'h080, 9'h080,         // smallest three-byte unit
		9'h0EF, 9'h0BF, 9'h0BF,         // 0xffff
		9'h0C2, 9'h041,                 // two-byte lead broken by ascii
		9'h0E4, 9'h0A0, 9'h041,         // three-byte broken after the middle byte
		9'h0E4, 9'h0C3, 9'h0A9,         // three-byte broken by a new lead
		9'h0E4, 9'h0A0, 9'h1C5,         // broken, then new lead flushed at end
		9'h0E2, 9'h182                  // end of string with lead and middle held
	};

	logic clk;
	logic arst_n;

	mu8_byte_if byte_ch ();
	mu8_unit_if unit_ch ();

	modified_utf8_to_utf16_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.units  (unit_ch)
	);

	// stimulus and expectation stores
	byte_req_t   pending_bytes[$];
	unit_rec_t   expected_units[$];
	byte_req_t   staged;
	logic        have_staged;
	int unsigned queued_random;
	logic        src_calm;

	// local decoder state
	logic [BYTE_W-1:0] lead_q;
	logic [BYTE_W-1:0] mid_q;
	logic [1:0]        held_n;
	logic [UNIT_W-1:0] step_unit [SLOTS];
	logic              step_bad  [SLOTS];
	int                step_n;

	// receiver side
	int unsigned hold_left;
	logic        sink_calm;

	// bookkeeping
	int unsigned errors;
	int unsigned bytes_sent;
	int unsigned strings_sent;
	int unsigned units_seen;
	int unsigned bad_seen;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ---------------------------------------------------------------
	// local decoder: mirrors the byte-level rules of the block
	// ---------------------------------------------------------------

	function automatic void put_unit(input logic [UNIT_W-1:0] u, input logic bad);
		if (step_n < SLOTS) begin
			step_unit[step_n] = u;
			step_bad[step_n]  = bad;
			step_n++;
		end
	endfunction

	// a byte seen with nothing held: ascii passes, strays and 1111 leads go out raw,
	// any other lead is held
	function automatic void start_byte(input logic [BYTE_W-1:0] b);
		if (!b[7]) begin
			put_unit({8'h00, b}, 1'b0);
		end else if ((b & CONT_MASK) == CONT_TAG || b[7:4] == BAD_NIB) begin
			put_unit({8'h00, b}, 1'b1);
		end else begin
			lead_q = b;
			held_n = HELD_LEAD;
		end
	endfunction

	// works out every code unit one byte causes and queues them in order
	function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic eos);
		unit_rec_t rec;
		logic      cont;
		cont   = (b & CONT_MASK) == CONT_TAG;
		step_n = 0;
		case (held_n)
			HELD_NONE: begin
				start_byte(b);
			end
			HELD_LEAD: begin
				if (cont && (lead_q & LEAD2_MASK) == LEAD2_TAG) begin
					put_unit({5'b00000, lead_q[4:0], b[5:0]}, 1'b0);
					held_n = HELD_NONE;
				end else if (cont) begin
					mid_q  = b;
					held_n = HELD_MID;
				end else begin
					// broken two- or three-byte lead
					put_unit({8'h00, lead_q}, 1'b1);
					held_n = HELD_NONE;
					start_byte(b);
				end
			end
			default: begin
				if (cont) begin
					put_unit({lead_q[3:0], mid_q[5:0], b[5:0]}, 1'b0);
					held_n = HELD_NONE;
				end else begin
					// lead and middle both go out raw, the middle as a stray
					put_unit({8'h00, lead_q}, 1'b1);
					put_unit({8'h00, mid_q}, 1'b1);
					held_n = HELD_NONE;
					start_byte(b);
				end
			end
		endcase
		// end of string flushes whatever is still held
		if (eos) begin
			if (held_n != HELD_NONE)
				put_unit({8'h00, lead_q}, 1'b1);
			if (held_n != HELD_NONE && held_n != HELD_LEAD)
				put_unit({8'h00, mid_q}, 1'b1);
			held_n = HELD_NONE;
		end
		for (int k = 0; k < step_n; k++) begin
			rec.code_unit   = step_unit[k];
			rec.malformed   = step_bad[k];
			rec.last_of_run = (k == step_n - 1);
			rec.string_done = (k == step_n - 1) && eos;
			expected_units.push_back(rec);
		end
	endfunction

	// ---------------------------------------------------------------
	// stimulus generation
	// ---------------------------------------------------------------

	// queue one byte; calm stretches send back to back
	task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic eos);
		byte_req_t req;
		if ($urandom_range(0, 31) == 0)
			src_calm = ~src_calm;
		req.value = b;
		req.eos   = eos;
		req.gap   = src_calm ? 0 : $urandom_range(0, MAX_GAP);
		pending_bytes.push_back(req);
	endtask

	// one random string: mostly well-formed characters with random content,
	// with some noise bytes and truncated sequences mixed in
	task automatic queue_string();
		logic [BYTE_W-1:0] chunk[$];
		int                chars;
		chars = $urandom_range(1, 10);
		repeat (chars) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					chunk.push_back(8'($urandom_range(8'h00, 8'h7F)));
				end
				3, 4: begin
					chunk.push_back(8'($urandom_range(8'hC0, 8'hDF)));
					chunk.push_back(8'($urandom_range(8'h80, 8'hBF)));
				end
				5, 6: begin
					chunk.push_back(8'($urandom_range(8'hE0, 8'hEF)));
					chunk.push_back(8'($urandom_range(8'h80, 8'hBF)));
					chunk.push_back(8'($urandom_range(8'h80, 8'hBF)));
				end
				7: begin
					chunk.push_back(8'($urandom_range(8'h00, 8'hFF)));
				end
				8: begin
					// truncated sequence, broken by whatever follows or by the end
					chunk.push_back(8'($urandom_range(8'hC0, 8'hEF)));
					if ($urandom_range(0, 1))
						chunk.push_back(8'($urandom_range(8'h80, 8'hBF)));
				end
				default: begin
					// stray continuation or 1111 lead
					if ($urandom_range(0, 1))
						chunk.push_back(8'($urandom_range(8'h80, 8'hBF)));
					else
						chunk.push_back(8'($urandom_range(8'hF0, 8'hFF)));
				end
			endcase
		end
		for (int i = 0; i < chunk.size(); i++)
			queue_byte(chunk[i], i == chunk.size() - 1);
		queued_random += chunk.size();
	endtask

	// ---------------------------------------------------------------
	// main sequence: fill the queue, reset, wait for the drain, report
	// ---------------------------------------------------------------

	initial begin
		arst_n                = 1'b0;
		byte_ch.valid         = 1'b0;
		byte_ch.data_byte     = '0;
		byte_ch.end_of_string = 1'b0;
		unit_ch.ready         = 1'b0;
		have_staged           = 1'b0;
		queued_random         = 0;
		src_calm              = 1'b0;
		sink_calm             = 1'b0;
		hold_left             = 0;
		lead_q                = '0;
		mid_q                 = '0;
		held_n                = HELD_NONE;
		errors                = 0;
		bytes_sent            = 0;
		strings_sent          = 0;
		units_seen            = 0;
		bad_seen              = 0;

		foreach (OPENING[i])
			queue_byte(OPENING[i][7:0], OPENING[i][8]);
		while (queued_random < RANDOM_LEN)
			queue_string();

		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;

		// every byte transferred, then every expected unit taken
		while (pending_bytes.size() != 0 || have_staged || byte_ch.valid)
			@(posedge clk);
		while (expected_units.size() != 0)
			@(posedge clk);
		// room for any stray unit to show up late
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d bytes in %0d strings; checked %0d code units, %0d of them malformed",
			bytes_sent, strings_sent, units_seen, bad_seen);
		if (errors == 0) begin
			$display("modified_utf8_to_utf16_decoder_test: clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("modified_utf8_to_utf16_decoder_test: errors");
		end
		$finish;
	end

	// ---------------------------------------------------------------
	// byte driver: predicts on each transfer, then offers the next byte
	// after its drawn gap
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid         <= 1'b0;
			byte_ch.data_byte     <= '0;
			byte_ch.end_of_string <= 1'b0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				decode_byte(byte_ch.data_byte, byte_ch.end_of_string);
				bytes_sent++;
				if (byte_ch.end_of_string)
					strings_sent++;
			end
			// the slot is free when nothing is offered or the offer was just taken
			if (!byte_ch.valid || byte_ch.ready) begin
				if (!have_staged && pending_bytes.size() != 0) begin
					staged      = pending_bytes.pop_front();
					have_staged = 1'b1;
				end
				if (have_staged && staged.gap == 0) begin
					byte_ch.valid         <= 1'b1;
					byte_ch.data_byte     <= staged.value;
					byte_ch.end_of_string <= staged.eos;
					have_staged = 1'b0;
				end else begin
					byte_ch.valid <= 1'b0;
					if (have_staged)
						staged.gap--;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// unit monitor: checks each transfer against the oldest expectation,
	// then stalls for a drawn number of cycles
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		unit_rec_t want;
		if (!arst_n) begin
			unit_ch.ready <= 1'b0;
		end else begin
			if (unit_ch.valid && unit_ch.ready) begin
				units_seen++;
				if (unit_ch.malformed)
					bad_seen++;
				if (expected_units.size() == 0) begin
					errors++;
					$display("%0t: unexpected code unit %h malformed %b last %b done %b",
						$time, unit_ch.code_unit, unit_ch.malformed,
						unit_ch.last_of_run, unit_ch.string_done);
				end else begin
					want = expected_units.pop_front();
					if (unit_ch.code_unit !== want.code_unit) begin
						errors++;
						$display("%0t: code_unit expected %h actual %h",
							$time, want.code_unit, unit_ch.code_unit);
					end
					if (unit_ch.malformed !== want.malformed) begin
						errors++;
						$display("%0t: malformed expected %b actual %b (unit %h)",
							$time, want.malformed, unit_ch.malformed, want.code_unit);
					end
					if (unit_ch.last_of_run !== want.last_of_run) begin
						errors++;
						$display("%0t: last_of_run expected %b actual %b (unit %h)",
							$time, want.last_of_run, unit_ch.last_of_run, want.code_unit);
					end
					if (unit_ch.string_done !== want.string_done) begin
						errors++;
						$display("%0t: string_done expected %b actual %b (unit %h)",
							$time, want.string_done, unit_ch.string_done, want.code_unit);
					end
				end
				// stall drawn per unit, none during calm stretches
				if ($urandom_range(0, 39) == 0)
					sink_calm = ~sink_calm;
				hold_left = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (hold_left != 0) begin
				unit_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				unit_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: too long without a transfer on either side ends the run
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((byte_ch.valid && byte_ch.ready) || (unit_ch.valid && unit_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d units still expected",
				$time, idle_cycles, expected_units.size());
			$display("modified_utf8_to_utf16_decoder_test: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

FILE: sim.f
rtl/mu8_pkg.sv
rtl/mu8_byte_if.sv
rtl/mu8_unit_if.sv
rtl/mu8_front.sv
rtl/mu8_fifo.sv
rtl/mu8_back.sv
rtl/modified_utf8_to_utf16_decoder.sv
tb/modified_utf8_to_utf16_decoder_test.sv
